### hw/rtl/pida_pkg.sv
// Shared constants, codes and types for the process id allocator.
`timescale 1ns / 1ps

package pida_pkg;

  localparam int CAPACITY = 64;
  localparam int PID_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int USER_W   = 16;
  localparam int LEVEL_W  = 3;
  localparam int PRIO_W   = 3;

  // Request op codes; the unused code behaves like a lookup
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  // One process table entry
  typedef struct packed {
    logic [PID_W-1:0]   parent;
    logic [USER_W-1:0]  user;
    logic [LEVEL_W-1:0] level;
    logic [PRIO_W-1:0]  prio;
  } pida_entry_t;

  // Commands into the free-id stack
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PID_W-1:0] push_pid;
  } pida_stack_ctl_t;

  // What the free-id stack shows back
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PID_W-1:0]   top;
  } pida_stack_sts_t;

endpackage

### hw/rtl/pida_ifs.sv
// Request and response channel interfaces of the process id allocator.
`timescale 1ns / 1ps

interface pida_req_if;
  logic                          valid;
  logic                          ready;
  logic [pida_pkg::OP_W-1:0]     op;
  logic [pida_pkg::PID_W-1:0]    target_pid;
  logic [pida_pkg::PID_W-1:0]    parent_pid;
  logic [pida_pkg::USER_W-1:0]   owner_user;
  logic [pida_pkg::LEVEL_W-1:0]  run_level;
  logic [pida_pkg::PRIO_W-1:0]   sched_priority;

  modport source (output valid, op, target_pid, parent_pid, owner_user, run_level,
                  sched_priority, input ready);
  modport sink   (input valid, op, target_pid, parent_pid, owner_user, run_level,
                  sched_priority, output ready);
endinterface

interface pida_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pida_pkg::STATUS_W-1:0] status;
  logic [pida_pkg::PID_W-1:0]    given_pid;
  logic                          entry_active;
  logic [pida_pkg::PID_W-1:0]    entry_parent;
  logic [pida_pkg::USER_W-1:0]   entry_user;
  logic [pida_pkg::LEVEL_W-1:0]  entry_level;
  logic [pida_pkg::PRIO_W-1:0]   entry_priority;

  modport source (output valid, status, given_pid, entry_active, entry_parent,
                  entry_user, entry_level, entry_priority, input ready);
  modport sink   (input valid, status, given_pid, entry_active, entry_parent,
                  entry_user, entry_level, entry_priority, output ready);
endinterface

### hw/rtl/pida_free_stack.sv
// LIFO stack of freed process ids, with the top held in a register.
`timescale 1ns / 1ps

module pida_free_stack (
  input  logic                      clk,
  input  logic                      rst,
  input  pida_pkg::pida_stack_ctl_t ctl,
  output pida_pkg::pida_stack_sts_t sts
);
  import pida_pkg::*;

  logic [PID_W-1:0]   stack_mem [CAPACITY];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] below_idx;
  logic [PID_W-1:0]   top;
  logic [PID_W-1:0]   below;

  // Advance the fill count
  always_comb begin
    priority if (ctl.push) begin
      count_next = count + COUNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  // Entry just under the new top; never the slot written this cycle
  assign below_idx = count_next - COUNT_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the top in a register, prefetch the entry beneath it
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack_mem[count[PID_W-1:0]] <= ctl.push_pid;
      top <= ctl.push_pid;
    end else if (ctl.pop) begin
      top <= below;
    end
    below <= stack_mem[below_idx[PID_W-1:0]];
  end

  assign sts.count = count;
  assign sts.top   = top;

endmodule

### hw/rtl/process_id_allocator.sv
// Top level of the process id allocator: request decode, process table, response register.
`timescale 1ns / 1ps

// Hands out process ids and keeps one table entry per id. Each request
// (create, destroy, lookup) gives exactly one response. A request is
// taken in every cycle in which the response register is empty or being
// drained, and its response appears in the next cycle: a single pass runs
// from the request through the id stack, valid bits and table write into
// the response register. Create reuses the most recently freed id first,
// then the next never-used id; ids run up to CAPACITY-2. Table fields and
// freed ids sit in memories with registered reads; no clearing pass is
// needed after reset.
module process_id_allocator (
  input  logic       clk,
  input  logic       rst,
  pida_req_if.sink   req,
  pida_rsp_if.source rsp
);
  import pida_pkg::*;

  logic                 accept;
  logic                 is_create;
  logic                 is_destroy;
  logic                 in_use;
  logic                 create_ok;
  logic                 hw_full;
  logic [PID_W-1:0]     new_pid;
  logic [PID_W-1:0]     high_water;
  logic [PID_W-1:0]     high_water_next;
  logic [CAPACITY-1:0]  slot_valid;
  logic [CAPACITY-1:0]  slot_valid_next;
  pida_stack_ctl_t      stack_ctl;
  pida_stack_sts_t      stack_sts;
  pida_entry_t          table_mem [CAPACITY];
  pida_entry_t          entry_rd;
  logic [STATUS_W-1:0]  status_next;
  logic [PID_W-1:0]     pid_next;
  logic                 active_next;
  logic                 out_valid;
  logic [STATUS_W-1:0]  status_q;
  logic [PID_W-1:0]     pid_q;
  logic                 active_q;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_create  = (req.op == OP_CREATE);
  assign is_destroy = (req.op == OP_DESTROY);
  assign in_use     = slot_valid[req.target_pid];
  assign hw_full    = (high_water >= PID_W'(CAPACITY - 1));

  // Decode one request
  always_comb begin
    stack_ctl       = '0;
    high_water_next = high_water;
    slot_valid_next = slot_valid;
    create_ok       = 1'b0;
    new_pid         = high_water;
    status_next     = ST_OK;
    pid_next        = req.target_pid;
    active_next     = 1'b0;
    if (is_create) begin
      priority if (stack_sts.count != '0) begin
        new_pid       = stack_sts.top;
        stack_ctl.pop = accept;
        create_ok     = 1'b1;
      end else if (hw_full) begin
        status_next = ST_NO_FREE;
      end else begin
        high_water_next = high_water + PID_W'(1);
        create_ok       = 1'b1;
      end
      pid_next = create_ok ? new_pid : '0;
      if (create_ok) begin
        slot_valid_next[new_pid] = 1'b1;
      end
    end else if (!in_use) begin
      status_next = ST_NOT_USED;
    end else if (is_destroy) begin
      slot_valid_next[req.target_pid] = 1'b0;
      priority if (high_water != '0 && req.target_pid == high_water - PID_W'(1)) begin
        high_water_next = high_water - PID_W'(1);
      end else if (stack_sts.count < COUNT_W'(CAPACITY)) begin
        stack_ctl.push     = accept;
        stack_ctl.push_pid = req.target_pid;
      end
    end else begin
      active_next = 1'b1;
    end
  end

  pida_free_stack u_free_stack (
    .clk (clk),
    .rst (rst),
    .ctl (stack_ctl),
    .sts (stack_sts)
  );

  // Commit the allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
      slot_valid <= '0;
    end else if (accept) begin
      high_water <= high_water_next;
      slot_valid <= slot_valid_next;
    end
  end

  // Write a new entry on a successful create, read the target on every transaction
  always_ff @(posedge clk) begin
    if (accept && is_create && create_ok) begin
      table_mem[new_pid] <= '{parent: req.parent_pid, user: req.owner_user,
                              level: req.run_level, prio: req.sched_priority};
    end
    if (accept) begin
      entry_rd <= table_mem[req.target_pid];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      pid_q    <= pid_next;
      active_q <= active_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = status_q;
  assign rsp.given_pid      = pid_q;
  assign rsp.entry_active   = active_q;
  assign rsp.entry_parent   = active_q ? entry_rd.parent : '0;
  assign rsp.entry_user     = active_q ? entry_rd.user   : '0;
  assign rsp.entry_level    = active_q ? entry_rd.level  : '0;
  assign rsp.entry_priority = active_q ? entry_rd.prio   : '0;

endmodule

### hw/rtl/pida_checker.sv
// Port-level checks for the process id allocator, bound to the top level.
`timescale 1ns / 1ps

module pida_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pida_pkg::STATUS_W-1:0] rsp_status,
  input logic [pida_pkg::PID_W-1:0]    rsp_given_pid,
  input logic                          rsp_entry_active,
  input logic [pida_pkg::PID_W-1:0]    rsp_entry_parent,
  input logic [pida_pkg::USER_W-1:0]   rsp_entry_user,
  input logic [pida_pkg::LEVEL_W-1:0]  rsp_entry_level,
  input logic [pida_pkg::PRIO_W-1:0]   rsp_entry_priority
);
  import pida_pkg::*;

  // Every request transaction yields a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after request transaction");

  // A stalled response keeps its status, id, active flag and user field
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_given_pid) && $stable(rsp_entry_active) && $stable(rsp_entry_user))
    else $error("stalled response changed");

  // Only a response with status OK reports entry contents
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_entry_active |-> rsp_status == ST_OK)
    else $error("entry reported on failed request");

  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_entry_active |-> rsp_entry_parent == '0 &&
      rsp_entry_user == '0 && rsp_entry_level == '0 && rsp_entry_priority == '0)
    else $error("entry fields set without an active entry");

  // A failed create hands out id zero
  a_no_free_pid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_NO_FREE |-> rsp_given_pid == '0)
    else $error("failed create returned a nonzero id");

endmodule

bind process_id_allocator pida_checker u_pida_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_given_pid      (rsp.given_pid),
  .rsp_entry_active   (rsp.entry_active),
  .rsp_entry_parent   (rsp.entry_parent),
  .rsp_entry_user     (rsp.entry_user),
  .rsp_entry_level    (rsp.entry_level),
  .rsp_entry_priority (rsp.entry_priority)
);
